// File: rtl/core/imm_pkg.sv
// Shared constants and codes for the integer matrix multiply core.
`timescale 1ns / 1ps

package imm_pkg;

    localparam int DIM_W  = 4;
    localparam int IDX_W  = 3;
    localparam int ACC_W  = 32;
    localparam int VAL_W  = 16;
    localparam int OP_W   = 2;
    localparam int CFG_IDX_W = 2;

    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 40;

    typedef logic [OP_W-1:0]      op_t;
    typedef logic [DIM_W-1:0]     dim_t;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    localparam op_t OP_LOAD_A = 2'd0;
    localparam op_t OP_LOAD_B = 2'd1;
    localparam op_t OP_START  = 2'd2;

    localparam cfg_idx_t REG_ROWS_A = 2'd0;
    localparam cfg_idx_t REG_COLS_A = 2'd1;
    localparam cfg_idx_t REG_ROWS_B = 2'd2;
    localparam cfg_idx_t REG_COLS_B = 2'd3;

    localparam dim_t ROWS_A_RST = 4'd2;
    localparam dim_t COLS_A_RST = 4'd2;
    localparam dim_t ROWS_B_RST = 4'd2;
    localparam dim_t COLS_B_RST = 4'd1;

endpackage

// File: rtl/core/imm_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module imm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                                     aclk,
    input  logic                                     wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                         wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// File: rtl/core/integer_matrix_multiply_core.sv
// Integer matrix multiply C = A x B with one shared multiply-accumulate unit.
// Operation: a load word writes one element of A or B; a start word gives one result per
// element of C, each after cols_a multiply-accumulate steps (cols_a capped at MAX_DIM), held
// back while m_tready holds low; a dimension error gives one result for the start word.
// s_tready stays low from the start word to the last result.
// Throughput: set by the single multiplier and the one read port of each store.
// Reset: synchronous, active low; clears control and sets registers to defaults;
// store contents stay undefined until written.
`timescale 1ns / 1ps

module integer_matrix_multiply_core #(
    parameter int MAX_DIM    = 8,
    parameter int ELEM_WIDTH = 16
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // row [2:0], col [5:3], element_value [21:6], zero fill [23:22]
    input  logic [imm_pkg::S_TDATA_W-1:0]    s_tdata,
    // operation [1:0]
    input  logic [imm_pkg::OP_W-1:0]        s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // out_row [2:0], out_col [5:3], product_value [37:6], zero fill [39:38]
    output logic [imm_pkg::M_TDATA_W-1:0]    m_tdata,
    output logic                             m_tlast,
    // dim_error [0]
    output logic                             m_tuser,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [imm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [imm_pkg::DIM_W-1:0]       cfg_wdata
);

    import imm_pkg::*;

    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_MAC   = 2'd1;
    localparam logic [1:0] S_DRAIN = 2'd2;
    localparam logic [1:0] S_EMIT  = 2'd3;

    function automatic dim_t sat_dim(input dim_t r);
        return (r > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : r;
    endfunction

    function automatic logic [AW-1:0] addr_of(input logic [IDX_W-1:0] r,
                                              input logic [IDX_W-1:0] c);
        logic [6:0] lin;
        lin = 7'(r) * 7'(MAX_DIM) + 7'(c);
        return lin[AW-1:0];
    endfunction

    dim_t rows_a_reg, cols_a_reg, rows_b_reg, cols_b_reg;
    dim_t dim_m, dim_k, dim_kb, dim_n;

    logic [1:0] state_reg, state_next;
    dim_t       i_reg, i_next, j_reg, j_next, k_reg, k_next;
    logic       err_reg, err_next;
    logic       acc_clr;
    logic       issue;

    logic                  rd_vld_reg, mul_vld_reg;
    logic [ELEM_WIDTH-1:0] a_rd, b_rd;
    logic [ACC_W-1:0]      a_ext, b_ext;
    logic [ACC_W-1:0]      mul_reg, acc_reg;

    logic                  out_valid_reg;
    logic [IDX_W-1:0]      out_row_reg, out_col_reg;
    logic [ACC_W-1:0]      out_val_reg;
    logic                  out_last_reg, out_err_reg;
    logic                  out_free, out_load, res_last;

    op_t                   in_op;
    logic [IDX_W-1:0]      in_row, in_col;
    logic [VAL_W-1:0]      in_val;
    logic                  in_acc, in_range;
    logic                  wr_a, wr_b;
    logic [AW-1:0]         wr_addr, rd_addr_a, rd_addr_b;
    logic [ELEM_WIDTH-1:0] wr_data;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_a_reg <= ROWS_A_RST;
            cols_a_reg <= COLS_A_RST;
            rows_b_reg <= ROWS_B_RST;
            cols_b_reg <= COLS_B_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_ROWS_A: rows_a_reg <= cfg_wdata;
                REG_COLS_A: cols_a_reg <= cfg_wdata;
                REG_ROWS_B: rows_b_reg <= cfg_wdata;
                REG_COLS_B: cols_b_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign dim_m  = sat_dim(rows_a_reg);
    assign dim_k  = sat_dim(cols_a_reg);
    assign dim_kb = sat_dim(rows_b_reg);
    assign dim_n  = sat_dim(cols_b_reg);

    assign in_op    = s_tuser;
    assign in_row   = s_tdata[2:0];
    assign in_col   = s_tdata[5:3];
    assign in_val   = s_tdata[21:6];
    assign s_tready = (state_reg == S_IDLE);
    assign in_acc   = s_tvalid && s_tready;
    assign in_range = (DIM_W'(in_row) < DIM_W'(MAX_DIM)) && (DIM_W'(in_col) < DIM_W'(MAX_DIM));
    assign wr_a     = in_acc && in_range && (in_op == OP_LOAD_A);
    assign wr_b     = in_acc && in_range && (in_op == OP_LOAD_B);
    assign wr_addr  = addr_of(in_row, in_col);
    assign wr_data  = ELEM_WIDTH'($signed(in_val));

    assign rd_addr_a = addr_of(i_reg[IDX_W-1:0], k_reg[IDX_W-1:0]);
    assign rd_addr_b = addr_of(k_reg[IDX_W-1:0], j_reg[IDX_W-1:0]);

    imm_ram #(.WIDTH(ELEM_WIDTH), .DEPTH(DEPTH)) u_a_store (
        .aclk    (aclk),
        .wr_en   (wr_a),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr_a),
        .rd_data (a_rd)
    );

    imm_ram #(.WIDTH(ELEM_WIDTH), .DEPTH(DEPTH)) u_b_store (
        .aclk    (aclk),
        .wr_en   (wr_b),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr_b),
        .rd_data (b_rd)
    );

    assign out_free = !out_valid_reg || m_tready;
    assign res_last = ((i_reg + 4'd1) == dim_m) && ((j_reg + 4'd1) == dim_n);

    always_comb begin
        state_next = state_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        err_next   = err_reg;
        acc_clr    = 1'b0;
        issue      = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            S_IDLE: begin
                if (in_acc && (in_op == OP_START)) begin
                    i_next  = '0;
                    j_next  = '0;
                    k_next  = '0;
                    acc_clr = 1'b1;
                    if (dim_k != dim_kb) begin
                        err_next   = 1'b1;
                        state_next = S_EMIT;
                    end else if ((dim_m != '0) && (dim_n != '0)) begin
                        err_next   = 1'b0;
                        state_next = S_MAC;
                    end
                end
            end
            S_MAC: begin
                if (k_reg < dim_k) begin
                    issue  = 1'b1;
                    k_next = k_reg + 4'd1;
                end else begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!rd_vld_reg && !mul_vld_reg) begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    out_load = 1'b1;
                    if (err_reg || res_last) begin
                        state_next = S_IDLE;
                    end else begin
                        state_next = S_MAC;
                        k_next     = '0;
                        acc_clr    = 1'b1;
                        if ((j_reg + 4'd1) == dim_n) begin
                            j_next = '0;
                            i_next = i_reg + 4'd1;
                        end else begin
                            j_next = j_reg + 4'd1;
                        end
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            i_reg       <= '0;
            j_reg       <= '0;
            k_reg       <= '0;
            err_reg     <= 1'b0;
            rd_vld_reg  <= 1'b0;
            mul_vld_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            i_reg       <= i_next;
            j_reg       <= j_next;
            k_reg       <= k_next;
            err_reg     <= err_next;
            rd_vld_reg  <= issue;
            mul_vld_reg <= rd_vld_reg;
        end
    end

    assign a_ext = ACC_W'($signed(a_rd));
    assign b_ext = ACC_W'($signed(b_rd));

    always_ff @(posedge aclk) begin
        mul_reg <= a_ext * b_ext;
        if (acc_clr) begin
            acc_reg <= '0;
        end else if (mul_vld_reg) begin
            acc_reg <= acc_reg + mul_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_row_reg  <= err_reg ? '0 : i_reg[IDX_W-1:0];
            out_col_reg  <= err_reg ? '0 : j_reg[IDX_W-1:0];
            out_val_reg  <= err_reg ? '0 : acc_reg;
            out_last_reg <= err_reg || res_last;
            out_err_reg  <= err_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_val_reg, out_col_reg, out_row_reg};
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_err_reg;

    a_load_only_in_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> $past(state_reg == S_EMIT))
        else $error("result word loaded outside emit");

    a_emit_pipe_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_EMIT) |-> (!rd_vld_reg && !mul_vld_reg))
        else $error("emit with products still in flight");

    a_k_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_MAC) |-> (k_reg <= dim_k))
        else $error("inner index past column count");

    a_err_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tlast && (m_tdata == '0)))
        else $error("error word not last or not zero");

    a_busy_not_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        (mul_vld_reg || rd_vld_reg) |-> !s_tready)
        else $error("input taken during accumulation");

endmodule
